@@ hw/rtl/rnt_pkg.sv @@
`timescale 1ns / 1ps

package rnt_pkg;

	// Table size and the index and count widths that follow from it.
	localparam int TABLE_DEPTH = 16;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int PW = IW + 1;

	// Operation codes of the mode field.
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_REM = 2'd1;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_OWN = 2'd0;
	localparam logic [1:0] REG_INTERVAL = 2'd1;
	localparam logic [1:0] REG_ASP = 2'd2;

	// One stored table entry.
	typedef struct packed {
		logic [30:0] nb;
		logic [15:0] hops;
		logic [31:0] seq;
		logic [30:0] up;
		logic        mesh;
		logic [31:0] heard;
	} entry_t;

	// Results of the shared compare unit for one stored entry.
	typedef struct packed {
		logic match;
		logic above;
		logic child;
	} eval_t;

	// Counts wider than the output saturate at 31.
	function automatic logic [4:0] sat5(logic [PW-1:0] v);
		if (int'(v) > 31) begin
			return 5'd31;
		end
		return 5'(v);
	endfunction

endpackage

@@ hw/rtl/ranked_neighbor_table.sv @@
`timescale 1ns / 1ps

// Ranked neighbor table: up to 16 entries kept in rank order (higher
// sequence, then smaller distance, then larger neighbor address).
// Commands: raise start with mode, neighbor, distance, sequence_req,
// neighbor_next_hop, mesh_flag and now_ticks while busy is low; the word is
// taken at that edge. Mode 0 adds or updates, mode 1 removes, any other
// mode only queries. Exactly one result word follows, shown for one cycle
// with done high: the front entry, the entry count, the mesh child count
// and the overflow flag. The receiver cannot stall; the word must be
// taken in that cycle.
// Each command walks the entry memory with one shared compare unit; every
// entry visit waits for the registered memory read. An add goes through
// search, close gap, find place, open gap, write and count; a remove
// goes through search, close gap and count; a query only counts. After
// the result the block returns to idle before the next word can be taken.
// Reset empties the table and loads the register defaults; configuration
// is written over the APB port at addresses 0, 4 and 8.
module ranked_neighbor_table
	import rnt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [30:0] neighbor,
	input  logic [15:0] distance,
	input  logic [31:0] sequence_req,
	input  logic [30:0] neighbor_next_hop,
	input  logic        mesh_flag,
	input  logic [31:0] now_ticks,
	output logic        done,
	output logic        front_valid,
	output logic [30:0] front_neighbor,
	output logic [15:0] front_distance,
	output logic [31:0] front_sequence,
	output logic [4:0]  entry_count,
	output logic [4:0]  mesh_children,
	output logic        dropped
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_FIND = 8'b0000_0010,
		S_DEL  = 8'b0000_0100,
		S_POS  = 8'b0000_1000,
		S_INS  = 8'b0001_0000,
		S_WR   = 8'b0010_0000,
		S_CNT  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);

	state_t        st_q;
	logic          ph_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] cnt_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] kids_q;
	logic          drop_q;
	logic [15:0]   fdist_q;
	logic [30:0]   own_q;
	logic [31:0]   intv_q;
	logic          asp_q;
	logic [1:0]    mode_q;
	entry_t        item_q;

	entry_t        rd;
	eval_t         ev;
	logic [15:0]   fdist;
	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;
	logic          cfg_wr;
	logic [PW-1:0] neff;
	logic          after_add;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			intv_q <= 32'd1000;
			asp_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_OWN:      own_q <= pwdata[30:0];
				REG_INTERVAL: intv_q <= pwdata;
				REG_ASP:      asp_q <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OWN:      prdata = {1'b0, own_q};
			REG_INTERVAL: prdata = intv_q;
			REG_ASP:      prdata = {31'd0, asp_q};
			default:      prdata = '0;
		endcase
	end

	// Entry memory and the shared compare unit.
	rnt_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_q[IW-1:0]),
		.rdata (rd)
	);

	assign fdist = (ptr_q == '0) ? rd.hops : fdist_q;

	rnt_eval u_eval (
		.ent         (rd),
		.nb          (item_q.nb),
		.hops        (item_q.hops),
		.seq         (item_q.seq),
		.now         (item_q.heard),
		.front_dist  (fdist),
		.own_address (own_q),
		.interval    (intv_q),
		.asp         (asp_q),
		.ev          (ev)
	);

	// Memory writes: shift up on delete, shift down on insert, then the new word.
	always_comb begin
		we = 1'b0;
		waddr = ptr_q[IW-1:0];
		wdata = rd;
		if (st_q == S_DEL && ph_q) begin
			we = 1'b1;
			waddr = IW'(ptr_q - PW'(1));
		end else if (st_q == S_INS && ph_q) begin
			we = 1'b1;
			waddr = IW'(ptr_q + PW'(1));
		end else if (st_q == S_WR) begin
			we = 1'b1;
			waddr = pos_q[IW-1:0];
			wdata = item_q;
		end
	end

	assign after_add = (mode_q == MODE_ADD);
	assign neff = (cnt_q == DEPTH_P) ? DEPTH_P - PW'(1) : cnt_q;
	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_DONE);

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph_q <= 1'b0;
			ptr_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			kids_q <= '0;
			drop_q <= 1'b0;
			front_valid <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					ph_q <= 1'b0;
					ptr_q <= '0;
					drop_q <= 1'b0;
					if (start) begin
						if (mode != MODE_ADD && mode != MODE_REM) begin
							st_q <= S_CNT;
						end else if (cnt_q != '0) begin
							st_q <= S_FIND;
						end else if (mode == MODE_ADD) begin
							st_q <= S_POS;
						end else begin
							st_q <= S_CNT;
						end
					end
				end
				S_FIND: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (ev.match) begin
							st_q <= S_DEL;
							ptr_q <= ptr_q + PW'(1);
						end else if (ptr_q == cnt_q - PW'(1)) begin
							st_q <= after_add ? S_POS : S_CNT;
							ptr_q <= '0;
						end else begin
							ptr_q <= ptr_q + PW'(1);
						end
					end
				end
				S_DEL: begin
					if (!ph_q) begin
						if (ptr_q == cnt_q) begin
							cnt_q <= cnt_q - PW'(1);
							st_q <= after_add ? S_POS : S_CNT;
							ptr_q <= '0;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_POS: begin
					if (!ph_q && ptr_q != cnt_q) begin
						ph_q <= 1'b1;
					end else if (ph_q && !ev.above) begin
						ph_q <= 1'b0;
						ptr_q <= ptr_q + PW'(1);
					end else begin
						// Place found: ptr_q is the insertion point.
						ph_q <= 1'b0;
						pos_q <= ptr_q;
						drop_q <= (cnt_q == DEPTH_P);
						if (ptr_q == DEPTH_P) begin
							st_q <= S_CNT;
							ptr_q <= '0;
						end else begin
							cnt_q <= neff;
							if (neff > ptr_q) begin
								st_q <= S_INS;
								ptr_q <= neff - PW'(1);
							end else begin
								st_q <= S_WR;
							end
						end
					end
				end
				S_INS: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (ptr_q == pos_q) begin
							st_q <= S_WR;
						end else begin
							ptr_q <= ptr_q - PW'(1);
						end
					end
				end
				S_WR: begin
					cnt_q <= cnt_q + PW'(1);
					st_q <= S_CNT;
					ptr_q <= '0;
					ph_q <= 1'b0;
				end
				S_CNT: begin
					if (!ph_q) begin
						if (ptr_q == '0) begin
							front_valid <= 1'b0;
							kids_q <= '0;
						end
						if (ptr_q == cnt_q) begin
							st_q <= S_DONE;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						ph_q <= 1'b0;
						if (ptr_q == '0) begin
							front_valid <= 1'b1;
						end
						if (ev.child) begin
							kids_q <= kids_q + PW'(1);
						end
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_DONE: begin
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command word and the front entry fields.
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			mode_q <= mode;
			item_q <= '{nb: neighbor, hops: distance, seq: sequence_req,
				up: neighbor_next_hop, mesh: mesh_flag, heard: now_ticks};
		end
		if (st_q == S_CNT && ph_q && ptr_q == '0) begin
			fdist_q <= rd.hops;
			front_neighbor <= rd.nb;
			front_distance <= rd.hops;
			front_sequence <= rd.seq;
		end else if (st_q == S_CNT && !ph_q && ptr_q == '0) begin
			front_neighbor <= '0;
			front_distance <= '0;
			front_sequence <= '0;
		end
	end

	assign entry_count = sat5(cnt_q);
	assign mesh_children = sat5(kids_q);
	assign dropped = drop_q;

endmodule

@@ hw/rtl/rnt_mem.sv @@
`timescale 1ns / 1ps

module rnt_mem
	import rnt_pkg::*;
(
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [TABLE_DEPTH];
	entry_t rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/rnt_eval.sv @@
`timescale 1ns / 1ps

module rnt_eval
	import rnt_pkg::*;
(
	input  entry_t      ent,
	input  logic [30:0] nb,
	input  logic [15:0] hops,
	input  logic [31:0] seq,
	input  logic [31:0] now,
	input  logic [15:0] front_dist,
	input  logic [30:0] own_address,
	input  logic [31:0] interval,
	input  logic        asp,
	output eval_t       ev
);

	logic [32:0] age;
	logic [32:0] limit;
	logic        fresh;
	logic        child;

	// Child test: mesh member, farther than front by over one, fresh, upstream allowed.
	assign age = {1'b0, now} - {1'b0, ent.heard};
	assign limit = {interval, 1'b0};
	assign fresh = (now < ent.heard) || (age <= limit);
	assign child = ent.mesh && ({1'b0, ent.hops} > ({1'b0, front_dist} + 17'd1))
		&& fresh && (asp || (ent.up <= own_address));

	// Rank: higher sequence, then smaller distance, then larger neighbor.
	always_comb begin
		ev.match = (ent.nb == nb);
		if (seq != ent.seq) begin
			ev.above = (seq > ent.seq);
		end else if (hops != ent.hops) begin
			ev.above = (hops < ent.hops);
		end else begin
			ev.above = (nb > ent.nb);
		end
		ev.child = child;
	end

endmodule

@@ hw/rtl/rnt_checker.sv @@
`timescale 1ns / 1ps

module rnt_checker
	import rnt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       front_valid,
	input logic [4:0] entry_count,
	input logic [4:0] mesh_children
);

	// An accepted word keeps the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy did not rise after start");

	// A result appears only during a command.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result outside a command");

	// The front is present exactly when the table holds entries.
	a_front: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_valid == (entry_count != 5'd0)))
		else $error("front_valid disagrees with entry_count");

	// Children never outnumber entries.
	a_kids: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mesh_children <= entry_count))
		else $error("more children than entries");

endmodule

bind ranked_neighbor_table rnt_checker u_rnt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.front_valid   (front_valid),
	.entry_count   (entry_count),
	.mesh_children (mesh_children)
);

@@ tb/sv/ranked_table_checker.sv @@
`timescale 1ns / 1ps

// Watches the command and configuration ports and mirrors the neighbor ranking.
// It then compares every result word with the oldest predicted front summary.
module ranked_table_checker
	import rnt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  mode,
	input  logic [30:0] neighbor,
	input  logic [15:0] distance,
	input  logic [31:0] sequence_req,
	input  logic [30:0] neighbor_next_hop,
	input  logic        mesh_flag,
	input  logic [31:0] now_ticks,
	input  logic        done,
	input  logic        front_valid,
	input  logic [30:0] front_neighbor,
	input  logic [15:0] front_distance,
	input  logic [31:0] front_sequence,
	input  logic [4:0]  entry_count,
	input  logic [4:0]  mesh_children,
	input  logic        dropped,
	output int          fail_count,
	output int          pending,
	output int          words_checked,
	output int          drops_seen
);

	typedef struct {
		logic [30:0] nb;
		logic [15:0] hops;
		logic [31:0] seq;
		logic [30:0] up;
		logic        mesh;
		logic [31:0] heard;
	} neighbor_rec_t;

	typedef struct packed {
		logic        fv;
		logic [30:0] fnb;
		logic [15:0] fdist;
		logic [31:0] fseq;
		logic [4:0]  cnt;
		logic [4:0]  kids;
		logic        drop;
	} summary_t;

	neighbor_rec_t ranked_q[$];
	summary_t      summary_q[$];
	logic [30:0]   own_addr;
	logic [31:0]   interval;
	logic          asp;

	// Removes the entry with the given neighbor, if there is one.
	function automatic void forget_neighbor(input logic [30:0] nb);
		for (int i = 0; i < ranked_q.size(); i++) begin
			if (ranked_q[i].nb == nb) begin
				ranked_q.delete(i);
				return;
			end
		end
	endfunction

	// True when the candidate outranks the stored entry.
	function automatic bit outranks(neighbor_rec_t c, neighbor_rec_t s);
		if (c.seq != s.seq) begin
			return c.seq > s.seq;
		end
		if (c.hops != s.hops) begin
			return c.hops < s.hops;
		end
		return c.nb > s.nb;
	endfunction

	// Inserts at the ranked place; returns 1 when the table overflowed.
	function automatic bit place_neighbor(neighbor_rec_t c);
		int pos;
		bit ovf;
		pos = 0;
		ovf = 0;
		forget_neighbor(c.nb);
		while (pos < ranked_q.size() && !outranks(c, ranked_q[pos])) begin
			pos++;
		end
		if (ranked_q.size() == TABLE_DEPTH) begin
			ovf = 1;
			if (pos == TABLE_DEPTH) begin
				return ovf;
			end
			void'(ranked_q.pop_back());
		end
		ranked_q.insert(pos, c);
		return ovf;
	endfunction

	// Counts fresh mesh members more than one hop farther than the front whose upstream is allowed.
	function automatic int count_mesh_kids(logic [31:0] now);
		int c;
		logic [32:0] limit;
		c = 0;
		limit = {interval, 1'b0};
		foreach (ranked_q[i]) begin
			if (ranked_q[i].mesh &&
			    {1'b0, ranked_q[i].hops} > {1'b0, ranked_q[0].hops} + 17'd1 &&
			    (now < ranked_q[i].heard ||
			     {1'b0, now - ranked_q[i].heard} <= limit) &&
			    (asp || ranked_q[i].up <= own_addr)) begin
				c++;
			end
		end
		return c;
	endfunction

	// Applies one accepted command word and returns the predicted result.
	function automatic summary_t apply_command();
		summary_t s;
		neighbor_rec_t c;
		s = '0;
		c.nb = neighbor;
		c.hops = distance;
		c.seq = sequence_req;
		c.up = neighbor_next_hop;
		c.mesh = mesh_flag;
		c.heard = now_ticks;
		if (mode == MODE_ADD) begin
			s.drop = place_neighbor(c);
		end else if (mode == MODE_REM) begin
			forget_neighbor(neighbor);
		end
		s.cnt = 5'(ranked_q.size());
		s.kids = 5'(count_mesh_kids(now_ticks));
		if (ranked_q.size() > 0) begin
			s.fv = 1'b1;
			s.fnb = ranked_q[0].nb;
			s.fdist = ranked_q[0].hops;
			s.fseq = ranked_q[0].seq;
		end
		return s;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	// Results are checked before a new word is taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		summary_t w;
		if (!arst_n) begin
			ranked_q.delete();
			summary_q.delete();
			own_addr = '0;
			interval = 32'd1000;
			asp = 1'b0;
		end else begin
			if (done) begin
				if (summary_q.size() == 0) begin
					fail_count++;
					$display("%0t: result word with nothing expected", $time);
				end else begin
					w = summary_q.pop_front();
					words_checked++;
					if (dropped) begin
						drops_seen++;
					end
					check_field("front_valid", 32'(w.fv), 32'(front_valid));
					check_field("front_neighbor", 32'(w.fnb), 32'(front_neighbor));
					check_field("front_distance", 32'(w.fdist), 32'(front_distance));
					check_field("front_sequence", w.fseq, front_sequence);
					check_field("entry_count", 32'(w.cnt), 32'(entry_count));
					check_field("mesh_children", 32'(w.kids), 32'(mesh_children));
					check_field("dropped", 32'(w.drop), 32'(dropped));
				end
			end
			if (start && !busy) begin
				summary_q.push_back(apply_command());
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_OWN: own_addr = pwdata[30:0];
					REG_INTERVAL: interval = pwdata;
					REG_ASP: asp = pwdata[0];
					default: ;
				endcase
			end
		end
		pending = summary_q.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
		words_checked = 0;
		drops_seen = 0;
	end

endmodule

@@ tb/sv/tb_ranked_neighbor_table.sv @@
`timescale 1ns / 1ps

module tb_ranked_neighbor_table;
	import rnt_pkg::*;

	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 200;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        start, busy;
	logic [1:0]  mode;
	logic [30:0] neighbor;
	logic [15:0] distance;
	logic [31:0] sequence_req;
	logic [30:0] neighbor_next_hop;
	logic        mesh_flag;
	logic [31:0] now_ticks;
	logic        done, front_valid;
	logic [30:0] front_neighbor;
	logic [15:0] front_distance;
	logic [31:0] front_sequence;
	logic [4:0]  entry_count, mesh_children;
	logic        dropped;
	int          fail_count, pending, words_checked, drops_seen;
	int          cycles;
	int          idle_pct;
	int          words_sent;
	int          reg_writes;
	logic [31:0] tick_base;
	logic [30:0] own_now;

	ranked_neighbor_table DUT (.*);

	ranked_table_checker u_checker (.*);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Register write: a setup phase, then an access phase.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_writes++;
		@(posedge clk);
	endtask

	// Waits until every predicted result has arrived and the block is quiet.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// Presents one command word and holds it until it is taken.
	task automatic send_word(input logic [1:0] m, input logic [30:0] nb,
	                         input logic [15:0] d, input logic [31:0] sq,
	                         input logic [30:0] up, input logic ms,
	                         input logic [31:0] now);
		mode <= m;
		neighbor <= nb;
		distance <= d;
		sequence_req <= sq;
		neighbor_next_hop <= up;
		mesh_flag <= ms;
		now_ticks <= now;
		start <= 1'b1;
		do begin
			@(posedge clk);
		end while (busy);
		words_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Random command word: mostly a small neighbor pool so that updates,
	// removals and overflow happen often, with full-range values mixed in.
	task automatic send_random();
		int r;
		logic [1:0] m;
		logic [30:0] nb, up;
		logic [15:0] d;
		logic [31:0] sq, now;
		r = $urandom_range(99);
		m = (r < 55) ? MODE_ADD : (r < 80) ? MODE_REM : (r < 96) ? MODE_QUERY : MODE_SPARE;
		nb = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 21));
		d = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		sq = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 5);
		r = $urandom_range(3);
		up = (r == 0) ? 31'($urandom) : own_now + 31'($urandom_range(0, 4)) - 31'd2;
		tick_base = tick_base + $urandom_range(0, 3);
		now = ($urandom_range(19) == 0) ? $urandom : tick_base - 32'($urandom_range(0, 2));
		send_word(m, nb, d, sq, up, 1'($urandom), now);
	endtask

	// Directed words: empty table, extremes, update, overflow both ways.
	task automatic run_directed();
		send_word(MODE_QUERY, '0, '0, '0, '0, 1'b0, '0);
		send_word(MODE_REM, 31'd5, '0, '0, '0, 1'b0, '0);
		send_word(MODE_SPARE, '1, '1, '1, '1, 1'b1, '1);
		send_word(MODE_ADD, '1, '0, '1, '1, 1'b1, '1);
		send_word(MODE_ADD, '0, '1, '0, '0, 1'b1, '0);
		send_word(MODE_QUERY, '0, '0, '0, '0, 1'b0, 32'd1999);
		send_word(MODE_ADD, '1, 16'd3, 32'd7, '0, 1'b0, 32'd10);
		send_word(MODE_REM, '1, '0, '0, '0, 1'b0, 32'd10);
		for (int i = 0; i < 16; i++) begin
			send_word(MODE_ADD, 31'(100 + i), 16'(i), 32'(1000 - i), '0, 1'b1, 32'd20);
		end
		send_word(MODE_ADD, '0, '1, '0, '0, 1'b1, 32'd30);
		send_word(MODE_ADD, 31'd7, '0, '1, '0, 1'b1, 32'd30);
		send_word(MODE_QUERY, '0, '0, '0, '0, 1'b0, 32'd5000);
	endtask

	initial begin
		logic [31:0] intervals [5];
		cycles = 0;
		words_sent = 0;
		reg_writes = 0;
		idle_pct = 16;
		tick_base = 32'd100;
		own_now = '0;
		intervals = '{32'd1, 32'hFFFF_FFFF, 32'd3, 32'd1000, 32'd2};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		mode <= MODE_QUERY;
		neighbor <= '0;
		distance <= '0;
		sequence_req <= '0;
		neighbor_next_hop <= '0;
		mesh_flag <= 1'b0;
		now_ticks <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Register defaults first, then five register settings.
		run_directed();
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			own_now = (ph == 0) ? 31'h7FFF_FFFF : (ph == 1) ? 31'd0 : 31'($urandom_range(0, 8));
			write_reg(REG_OWN, {1'b0, own_now});
			write_reg(REG_INTERVAL, intervals[ph]);
			write_reg(REG_ASP, 32'(ph % 2));
			if (ph == 2) begin
				write_reg(REG_UNUSED, '1);
			end
			for (int i = 0; i < 150; i++) begin
				idle_pct = (words_sent < 275) ? 16 : (words_sent < 525) ? 47 : 0;
				if (ph == 1 && i == 60) begin
					drain();
				end
				send_random();
			end
		end
		drain();

		$display("Ran %0d command words under %0d register writes; %0d results checked,",
		         words_sent, reg_writes, words_checked);
		$display("%0d of them reporting an overflow drop.", drops_seen);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/rnt_pkg.sv
hw/rtl/rnt_mem.sv
hw/rtl/rnt_eval.sv
hw/rtl/ranked_neighbor_table.sv
hw/rtl/rnt_checker.sv
tb/sv/ranked_table_checker.sv
tb/sv/tb_ranked_neighbor_table.sv
